@@ rtl/atp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atp_pkg
// Types and constants shared by the table-of-contents record parser.
// ----------------------------------------------------------------------------
package atp_pkg;

    localparam int unsigned HEADER_BYTES = 18;
    localparam logic [15:0] MAX_RECORD_SIZE_RESET = 16'd1024;

    localparam int unsigned CFG_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_TOC_LENGTH      = 1'b0,
        REG_MAX_RECORD_SIZE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_NAME     = 2'd1,
        KIND_BAD_SIZE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [31:0] toc_length;
        logic [15:0] max_record_size;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] item_position;
        logic [31:0] packed_size;
        logic [31:0] unpacked_size;
        logic [7:0]  compress_flag;
        logic [7:0]  type_code;
        logic [7:0]  name_byte;
        logic        record_last;
        logic        table_end;
    } res_t;

endpackage
`default_nettype wire

@@ rtl/atp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atp_byte_if / atp_rec_if
// Valid/ready channels for stream bytes and parsed record results.
// ----------------------------------------------------------------------------
interface atp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] toc_byte;

    modport source (output valid, output toc_byte, input ready);
    modport sink   (input valid, input toc_byte, output ready);
endinterface

interface atp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] item_position;
    logic [31:0] packed_size;
    logic [31:0] unpacked_size;
    logic [7:0]  compress_flag;
    logic [7:0]  type_code;
    logic [7:0]  name_byte;
    logic        record_last;
    logic        table_end;

    modport source (
        output valid, output kind, output item_position, output packed_size,
        output unpacked_size, output compress_flag, output type_code,
        output name_byte, output record_last, output table_end,
        input ready
    );
    modport sink (
        input valid, input kind, input item_position, input packed_size,
        input unpacked_size, input compress_flag, input type_code,
        input name_byte, input record_last, input table_end,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/atp_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atp_cfg_regs
// APB register file: table length and largest valid record size.
// ----------------------------------------------------------------------------
module atp_cfg_regs
    import atp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t sel;
    logic       wr_en;

    assign pready = 1'b1;
    assign sel    = reg_index_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_TOC_LENGTH:      cfg_next.toc_length      = pwdata;
                REG_MAX_RECORD_SIZE: cfg_next.max_record_size = pwdata[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_TOC_LENGTH:      prdata = cfg_reg.toc_length;
            REG_MAX_RECORD_SIZE: prdata = {16'd0, cfg_reg.max_record_size};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.toc_length      <= 32'd0;
            cfg_reg.max_record_size <= MAX_RECORD_SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ rtl/atp_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atp_parser
// Record state machine: assembles size and header words, counts name bytes,
// tracks consumed bytes; produces at most one result per accepted beat.
// ----------------------------------------------------------------------------
module atp_parser
    import atp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] toc_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output res_t            res
);

    typedef enum logic [1:0] {
        PH_SIZE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_NAME   = 2'd2
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [3:0]  idx_reg,       idx_next;
    logic [23:0] shift_reg,     shift_next;
    logic [15:0] size_reg,      size_next;
    logic [31:0] pos_reg,       pos_next;
    logic [31:0] packed_reg,    packed_next;
    logic [31:0] unpacked_reg,  unpacked_next;
    logic [7:0]  flag_reg,      flag_next;
    logic [15:0] remain_reg,    remain_next;
    logic [32:0] consumed_reg,  consumed_next;

    logic [31:0] word;
    logic [15:0] hdr_remain;
    logic [15:0] name_remain;
    logic        table_done;
    logic        bad_size;

    assign word        = {shift_reg, toc_byte};
    assign hdr_remain  = size_reg - 16'(HEADER_BYTES);
    assign name_remain = remain_reg - 16'd1;
    assign table_done  = consumed_reg >= {1'b0, cfg.toc_length};
    assign bad_size    = (word < 32'(HEADER_BYTES))
                      || (word > {16'd0, cfg.max_record_size});

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        size_next     = size_reg;
        pos_next      = pos_reg;
        packed_next   = packed_reg;
        unpacked_next = unpacked_reg;
        flag_next     = flag_reg;
        remain_next   = remain_reg;
        consumed_next = consumed_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.kind      = KIND_HEADER;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (idx_reg < 4'd12)
                begin
                    shift_next = word[23:0];
                    if (idx_reg == 4'd3)  pos_next      = word;
                    if (idx_reg == 4'd7)  packed_next   = word;
                    if (idx_reg == 4'd11) unpacked_next = word;
                    idx_next = idx_reg + 4'd1;
                end
                else if (idx_reg == 4'd12)
                begin
                    flag_next = toc_byte;
                    idx_next  = 4'd13;
                end
                else
                begin
                    remain_next       = hdr_remain;
                    idx_next          = 4'd0;
                    shift_next        = 24'd0;
                    res_valid         = 1'b1;
                    res.kind          = KIND_HEADER;
                    res.item_position = pos_reg;
                    res.packed_size   = packed_reg;
                    res.unpacked_size = unpacked_reg;
                    res.compress_flag = flag_reg;
                    res.type_code     = toc_byte;
                    if (hdr_remain == 16'd0)
                    begin
                        consumed_next   = consumed_reg + {17'd0, size_reg};
                        phase_next      = PH_SIZE;
                        res.record_last = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                    end
                end
            end
            PH_NAME:
            begin
                remain_next   = name_remain;
                res_valid     = 1'b1;
                res.kind      = KIND_NAME;
                res.name_byte = toc_byte;
                if (name_remain == 16'd0)
                begin
                    consumed_next   = consumed_reg + {17'd0, size_reg};
                    phase_next      = PH_SIZE;
                    idx_next        = 4'd0;
                    shift_next      = 24'd0;
                    res.record_last = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_SIZE;
                if (!(idx_reg == 4'd0 && table_done))
                begin
                    shift_next = word[23:0];
                    if (idx_reg < 4'd3)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        idx_next   = 4'd0;
                        shift_next = 24'd0;
                        if (bad_size)
                        begin
                            consumed_next   = consumed_reg + 33'd4;
                            res_valid       = 1'b1;
                            res.kind        = KIND_BAD_SIZE;
                            res.record_last = 1'b1;
                        end
                        else
                        begin
                            size_next  = word[15:0];
                            phase_next = PH_HEADER;
                        end
                    end
                end
            end
        endcase

        res.table_end = consumed_next >= {1'b0, cfg.toc_length};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIZE;
            idx_reg      <= 4'd0;
            shift_reg    <= 24'd0;
            size_reg     <= 16'd0;
            pos_reg      <= 32'd0;
            packed_reg   <= 32'd0;
            unpacked_reg <= 32'd0;
            flag_reg     <= 8'd0;
            remain_reg   <= 16'd0;
            consumed_reg <= 33'd0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            shift_reg    <= shift_next;
            size_reg     <= size_next;
            pos_reg      <= pos_next;
            packed_reg   <= packed_next;
            unpacked_reg <= unpacked_next;
            flag_reg     <= flag_next;
            remain_reg   <= remain_next;
            consumed_reg <= consumed_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/atp_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atp_out_stage
// Result register; takes a new result whenever empty or being drained.
// ----------------------------------------------------------------------------
module atp_out_stage
    import atp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire logic      res_valid,
    input  wire res_t      res,
    output logic           take_ok,
    atp_rec_if.source      rec_out
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign take_ok    = !valid_reg || rec_out.ready;
    assign valid_next = take_ok ? (fire && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_ok && fire && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign rec_out.valid         = valid_reg;
    assign rec_out.kind          = data_reg.kind;
    assign rec_out.item_position = data_reg.item_position;
    assign rec_out.packed_size   = data_reg.packed_size;
    assign rec_out.unpacked_size = data_reg.unpacked_size;
    assign rec_out.compress_flag = data_reg.compress_flag;
    assign rec_out.type_code     = data_reg.type_code;
    assign rec_out.name_byte     = data_reg.name_byte;
    assign rec_out.record_last   = data_reg.record_last;
    assign rec_out.table_end     = data_reg.table_end;

endmodule
`default_nettype wire

@@ rtl/archive_toc_record_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// archive_toc_record_parser_unit
// Table-of-contents record parser, one stream byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle when not stalled, with no bubbles between records.
// Each accepted byte updates the record state machine in the cycle it is
// taken; a byte that yields a result (header, name byte, bad size) shows up on
// rec_out in the next cycle from the result register. byte_in stalls only while
// that register holds a result the consumer has not taken. Size bytes (but a
// bad size's last), header bytes before the type byte and bytes past the table
// end yield no result. Registers (toc_length at 0x0, max_record_size at 0x4)
// must be written only while the stream is idle (a user rule, not enforced).
module archive_toc_record_parser_unit
    import atp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    atp_byte_if.sink                   byte_in,
    atp_rec_if.source                  rec_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    cfg_t cfg;
    res_t res;
    logic res_valid;
    logic take_ok;
    logic fire;

    assign byte_in.ready = take_ok;
    assign fire          = byte_in.valid && take_ok;

    atp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .toc_byte  (byte_in.toc_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    atp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .take_ok   (take_ok),
        .rec_out   (rec_out)
    );

endmodule
`default_nettype wire

@@ tb/atp_record_check.sv @@
// ----------------------------------------------------------------------------
// atp_record_check
// Watches the byte and result channels and the register port of the parser,
// predicts every result from the accepted stream bytes and compares each
// result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module atp_record_check
    import atp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    atp_byte_if                   bmon,
    atp_rec_if                    rmon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int unsigned           mismatches,
    output int unsigned           pending,
    output int unsigned           headers_seen,
    output int unsigned           names_seen,
    output int unsigned           bad_sizes_seen
);

    typedef enum logic [2:0] {
        AWAIT_SIZE = 3'd0,
        IN_HEADER  = 3'd1,
        IN_NAME    = 3'd2
    } parse_phase_t;

    logic [31:0]  cfg_toc_length = '0;
    logic [15:0]  cfg_max_size = MAX_RECORD_SIZE_RESET;

    parse_phase_t parse_phase = AWAIT_SIZE;
    logic [4:0]   field_idx = '0;
    logic [31:0]  word_shift = '0;
    logic [31:0]  rec_size = '0;
    logic [31:0]  hdr_position = '0;
    logic [31:0]  hdr_packed = '0;
    logic [31:0]  hdr_unpacked = '0;
    logic [7:0]   hdr_flag = '0;
    logic [15:0]  name_left = '0;
    logic [32:0]  consumed_bytes = '0;

    res_t         expected_records[$];
    res_t         predicted;
    res_t         oldest;
    bit           produced;

    task automatic close_record();
        consumed_bytes = consumed_bytes + {1'b0, rec_size};
        parse_phase = AWAIT_SIZE;
        field_idx = '0;
        word_shift = '0;
    endtask

    task automatic parse_stream_byte(input logic [7:0] b, output bit made, output res_t r);
        made = 1'b0;
        r = '0;
        case (parse_phase)
            IN_HEADER:
            begin
                if (field_idx < 12)
                begin
                    word_shift = {word_shift[23:0], b};
                    if (field_idx == 3)
                        hdr_position = word_shift;
                    if (field_idx == 7)
                        hdr_packed = word_shift;
                    if (field_idx == 11)
                        hdr_unpacked = word_shift;
                    field_idx = field_idx + 1'b1;
                end
                else if (field_idx == 12)
                begin
                    hdr_flag = b;
                    field_idx = 5'd13;
                end
                else
                begin
                    name_left = 16'(rec_size - HEADER_BYTES);
                    field_idx = '0;
                    word_shift = '0;
                    made = 1'b1;
                    r.kind = KIND_HEADER;
                    r.item_position = hdr_position;
                    r.packed_size = hdr_packed;
                    r.unpacked_size = hdr_unpacked;
                    r.compress_flag = hdr_flag;
                    r.type_code = b;
                    if (name_left == 0)
                    begin
                        close_record();
                        r.record_last = 1'b1;
                    end
                    else
                        parse_phase = IN_NAME;
                end
            end
            IN_NAME:
            begin
                name_left = name_left - 1'b1;
                made = 1'b1;
                r.kind = KIND_NAME;
                r.name_byte = b;
                if (name_left == 0)
                begin
                    close_record();
                    r.record_last = 1'b1;
                end
            end
            default:
            begin
                parse_phase = AWAIT_SIZE;
                // past the table end a new size field is never started
                if (!(field_idx == 0 && consumed_bytes >= {1'b0, cfg_toc_length}))
                begin
                    word_shift = {word_shift[23:0], b};
                    if (field_idx < 3)
                        field_idx = field_idx + 1'b1;
                    else
                    begin
                        rec_size = word_shift;
                        field_idx = '0;
                        word_shift = '0;
                        if (rec_size < HEADER_BYTES || rec_size > {16'd0, cfg_max_size})
                        begin
                            consumed_bytes = consumed_bytes + 33'd4;
                            made = 1'b1;
                            r.kind = KIND_BAD_SIZE;
                            r.record_last = 1'b1;
                        end
                        else
                            parse_phase = IN_HEADER;
                    end
                end
            end
        endcase
        if (made)
            r.table_end = (consumed_bytes >= {1'b0, cfg_toc_length});
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_toc_length = '0;
            cfg_max_size = MAX_RECORD_SIZE_RESET;
            parse_phase = AWAIT_SIZE;
            field_idx = '0;
            word_shift = '0;
            rec_size = '0;
            hdr_position = '0;
            hdr_packed = '0;
            hdr_unpacked = '0;
            hdr_flag = '0;
            name_left = '0;
            consumed_bytes = '0;
            expected_records.delete();
            mismatches = 0;
            headers_seen = 0;
            names_seen = 0;
            bad_sizes_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_index_t'(paddr[2]) == REG_TOC_LENGTH)
                    cfg_toc_length = pwdata;
                else
                    cfg_max_size = pwdata[15:0];
            end
            if (bmon.valid && bmon.ready)
            begin
                parse_stream_byte(bmon.toc_byte, produced, predicted);
                if (produced)
                    expected_records.push_back(predicted);
            end
            if (rmon.valid && rmon.ready)
            begin
                if (expected_records.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat of kind %0d with nothing expected",
                             $time, rmon.kind);
                end
                else
                begin
                    oldest = expected_records.pop_front();
                    check_field("kind", 32'(oldest.kind), 32'(rmon.kind));
                    check_field("item_position", oldest.item_position, rmon.item_position);
                    check_field("packed_size", oldest.packed_size, rmon.packed_size);
                    check_field("unpacked_size", oldest.unpacked_size, rmon.unpacked_size);
                    check_field("compress_flag", 32'(oldest.compress_flag),
                                32'(rmon.compress_flag));
                    check_field("type_code", 32'(oldest.type_code), 32'(rmon.type_code));
                    check_field("name_byte", 32'(oldest.name_byte), 32'(rmon.name_byte));
                    check_field("record_last", 32'(oldest.record_last),
                                32'(rmon.record_last));
                    check_field("table_end", 32'(oldest.table_end), 32'(rmon.table_end));
                    case (oldest.kind)
                        KIND_HEADER:   headers_seen++;
                        KIND_NAME:     names_seen++;
                        default:       bad_sizes_seen++;
                    endcase
                end
            end
            pending <= expected_records.size();
        end
    end

endmodule

@@ tb/tb_archive_toc_record_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_archive_toc_record_parser_unit
// Feeds the parser table-of-contents streams built from well-formed records
// with random content, bad sizes and noise words, under several register
// settings and idle/stall mixes; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_archive_toc_record_parser_unit;
    import atp_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    atp_byte_if bif ();
    atp_rec_if  rif ();

    int unsigned mismatches;
    int unsigned pending;
    int unsigned headers_seen;
    int unsigned names_seen;
    int unsigned bad_sizes_seen;

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned bytes_sent;
    int unsigned reg_writes;
    logic [15:0] cur_max;
    bit          long_hold_req;

    archive_toc_record_parser_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (bif),
        .rec_out (rif),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    atp_record_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .bmon           (bif),
        .rmon           (rif),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .pending        (pending),
        .headers_seen   (headers_seen),
        .names_seen     (names_seen),
        .bad_sizes_seen (bad_sizes_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result consumer; a hold request parks ready low for a long stretch
    initial
    begin
        int unsigned held;
        rif.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req <= 1'b0;
                rif.ready <= 1'b0;
                held = 0;
                while (held < 400)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            rif.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            bif.valid <= 1'b0;
            @(posedge clk);
        end
        bif.valid <= 1'b1;
        bif.toc_byte <= b;
        do
            @(posedge clk);
        while (!bif.ready);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            send_byte(w[8*k +: 8]);
    endtask

    task automatic send_record(input logic [31:0] sz, input logic [31:0] pos,
                               input logic [31:0] pk, input logic [31:0] up,
                               input logic [7:0] flag, input logic [7:0] typ);
        send_word(sz);
        if (sz >= HEADER_BYTES && sz <= {16'd0, cur_max})
        begin
            send_word(pos);
            send_word(pk);
            send_word(up);
            send_byte(flag);
            send_byte(typ);
            repeat (sz - HEADER_BYTES)
                send_byte($urandom_range(255));
        end
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MAX_RECORD_SIZE)
            cur_max = v[15:0];
        reg_writes++;
    endtask

    task automatic drain();
        bif.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned budget, input int unsigned src_pct,
                             input int unsigned snk_pct);
        int unsigned start_count;
        int unsigned pick;
        int unsigned hi;
        logic [31:0] sz;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        start_count = bytes_sent;
        while (bytes_sent - start_count < budget)
        begin
            pick = $urandom_range(99);
            hi = (cur_max > 300) ? 300 : cur_max;
            if (pick < 80)
            begin
                if (cur_max < HEADER_BYTES)
                    sz = $urandom_range(HEADER_BYTES - 1);
                else if (pick < 4)
                    sz = $urandom_range(hi, HEADER_BYTES);
                else
                    sz = $urandom_range((hi > 40) ? 40 : hi, HEADER_BYTES);
                send_record(sz, $urandom(), $urandom(), $urandom(),
                            $urandom_range(255), $urandom_range(255));
            end
            else if (pick < 95)
            begin
                case (pick % 4)
                    0:       sz = $urandom_range(HEADER_BYTES - 1);
                    1:       sz = {16'd0, cur_max} + 32'd1;
                    default: sz = $urandom();
                endcase
                send_record(sz, $urandom(), $urandom(), $urandom(),
                            $urandom_range(255), $urandom_range(255));
            end
            else
            begin
                // whole noise words keep the size framing aligned
                repeat (4 * $urandom_range(2, 1))
                    send_byte($urandom_range(255));
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        bif.valid = 1'b0;
        bif.toc_byte = '0;
        long_hold_req = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        bytes_sent = 0;
        reg_writes = 0;
        cur_max = MAX_RECORD_SIZE_RESET;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero table length: the stream is ignored
        reg_write(REG_TOC_LENGTH, 32'h0);
        send_byte(8'h00);
        send_byte(8'hFF);
        drain();

        reg_write(REG_TOC_LENGTH, 32'hFFFF_FFFF);
        reg_write(REG_MAX_RECORD_SIZE, 32'd1024);
        send_word(32'd17);
        send_word(32'hFFFF_FFFF);
        send_record(32'd18, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'hFF, 8'h00);
        send_record(32'd19, 32'h0, 32'hFFFF_FFFF, 32'h0, 8'h00, 8'hFF);
        drain();
        run_phase(250, 0, 0);

        reg_write(REG_MAX_RECORD_SIZE, 32'd18);
        run_phase(200, 63, 0);

        reg_write(REG_MAX_RECORD_SIZE, 32'd65535);
        long_hold_req <= 1'b1;
        run_phase(300, 0, 63);

        // table ends partway through this phase
        reg_write(REG_TOC_LENGTH, bytes_sent + $urandom_range(160, 60));
        run_phase(200, 27, 27);

        // maximum below the header size: every size is bad
        reg_write(REG_TOC_LENGTH, 32'hFFFF_FFFF);
        reg_write(REG_MAX_RECORD_SIZE, 32'd0);
        run_phase(150, 63, 63);

        reg_write(REG_MAX_RECORD_SIZE, $urandom_range(300, HEADER_BYTES));
        run_phase(300, 27, 27);

        $display("Sent %0d stream bytes across %0d register writes; checked %0d headers,",
                 bytes_sent, reg_writes, headers_seen);
        $display("%0d name bytes and %0d bad-size skips, with idle, stall and hold mixes.",
                 names_seen, bad_sizes_seen);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
